FILE: design/dgos_pkg.sv
// Shared types and constants for the diagonal Gaussian online scorer.
package dgos_pkg;

    localparam int DIM_DEFAULT  = 16;
    localparam int FRAC_DEFAULT = 16;

    localparam int ALPHA_W = 16;
    localparam int DATA_W  = 32;
    localparam int ACC_W   = 48;
    localparam int LN_W    = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd655;
    localparam logic [16:0]        ALPHA_ONE   = 17'h10000;

    // Shared multiplier: 49-bit operand times 33-bit operand, 8 bits a cycle
    localparam int MUL_X_W   = 49;
    localparam int MUL_Y_W   = 33;
    localparam int MUL_P_W   = MUL_X_W + MUL_Y_W;
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = (MUL_Y_W + MUL_DIGIT - 1) / MUL_DIGIT;

    // Squared-difference and quotient caps
    localparam int SQ_W = 47;
    localparam logic [SQ_W-1:0] SQ_CAP = {SQ_W{1'b1}};
    localparam int Q_W  = 51;
    localparam logic [Q_W-1:0] Q_CAP = {1'b1, {(Q_W-1){1'b0}}};

    // Divider: 65-bit dividend, two quotient bits a cycle
    localparam int DIV_N_W   = 66;
    localparam int DIV_STEPS = DIV_N_W / 2;

    // ln(2) in Q28
    localparam logic signed [28:0] LN2_Q28 = 29'sd186065280;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_SCORE  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MS_SQUARE,
        MS_DECAY,
        MS_MEAN,
        MS_VAR
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mem_read;
        logic     load_write;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     sq_capture;
        logic     t_capture;
        logic     nm_capture;
        logic     nv_write;
        logic     score_start;
        logic     acc_update;
        logic     err_set;
        logic     emit;
    } ctrl_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    last;
        logic    idx_ok;
        logic    var_zero;
        logic    mul_busy;
        logic    score_busy;
        logic    out_free;
    } dp_status_t;

endpackage

FILE: design/dgos_if.sv
// Request channel interfaces: sample input and score output.
interface dgos_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [3:0]         element_index;
    logic signed [31:0] sample_value;
    logic [31:0]        load_variance;
    logic               last_element;

    modport source (output valid, opcode, element_index, sample_value, load_variance,
                    last_element, input ready);
    modport sink   (input valid, opcode, element_index, sample_value, load_variance,
                    last_element, output ready);
endinterface

interface dgos_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] log_likelihood;
    logic               variance_error;

    modport source (output valid, log_likelihood, variance_error, input ready);
    modport sink   (input valid, log_likelihood, variance_error, output ready);
endinterface

FILE: design/dgos_div.sv
// Radix-4 restoring divider: 65-bit dividend by 32-bit divisor, quotient capped.
module dgos_div
    import dgos_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [64:0]       dividend,
    input  logic [31:0]       divisor,
    output logic              busy,
    output logic [Q_W-1:0]    quot
);

    localparam int CW = $clog2(DIV_STEPS);

    logic [DIV_N_W-1:0] n_reg;
    logic [DIV_N_W-1:0] q_reg;
    logic [31:0]        r_reg;
    logic [31:0]        d_reg;
    logic [CW-1:0]      cnt_reg;
    logic               busy_reg;

    logic [32:0] r1, r2;
    logic        ge1, ge2;
    logic [31:0] r1s, r2s;

    // two restoring steps per cycle
    always_comb
    begin
        r1  = {r_reg, n_reg[DIV_N_W-1]};
        ge1 = (r1 >= {1'b0, d_reg});
        r1s = ge1 ? 32'(r1 - {1'b0, d_reg}) : r1[31:0];
        r2  = {r1s, n_reg[DIV_N_W-2]};
        ge2 = (r2 >= {1'b0, d_reg});
        r2s = ge2 ? 32'(r2 - {1'b0, d_reg}) : r2[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_STEPS - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= {1'b0, dividend};
            q_reg <= '0;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            n_reg <= n_reg << 2;
            q_reg <= {q_reg[DIV_N_W-3:0], ge1, ge2};
            r_reg <= r2s;
        end
    end

    assign busy = busy_reg;
    assign quot = (q_reg > DIV_N_W'(Q_CAP)) ? Q_CAP : q_reg[Q_W-1:0];

endmodule

FILE: design/dgos_ln.sv
// Iterative natural log: normalize, 30 squaring steps for log2, scale by ln 2.
module dgos_ln
    import dgos_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [31:0]            v,
    output logic                   busy,
    output logic signed [LN_W-1:0] ln_out
);

    localparam int LN_SHIFT = 30 - FRAC_BITS - 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_NORM,
        PH_SEED,
        PH_ITER,
        PH_SCALE
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [31:0]            m_reg, m_next;
    logic [4:0]             p_reg, p_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic signed [36:0]     l2_reg, l2_next;
    logic signed [LN_W-1:0] ln_reg, ln_next;

    logic [5:0]         sh;
    logic [61:0]        prod;
    logic [31:0]        mm;
    logic signed [36:0] l2_seed;
    logic signed [36:0] l2_shr;
    logic signed [65:0] lnp;

    always_comb
    begin
        sh      = 6'd16 >> cnt_reg[2:0];
        prod    = 62'(m_reg[30:0]) * 62'(m_reg[30:0]);
        mm      = prod[61:30];
        l2_seed = ($signed({32'd0, p_reg}) - $signed(37'(FRAC_BITS))) <<< 30;
        l2_shr  = l2_reg >>> LN_SHIFT;
        lnp     = l2_shr * LN2_Q28;

        phase_next = phase_reg;
        m_next     = m_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;
        l2_next    = l2_reg;
        ln_next    = ln_reg;

        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    m_next     = v;
                    p_next     = 5'd31;
                    cnt_next   = '0;
                    phase_next = PH_NORM;
                end
            end
            // binary search for the leading one: 16, 8, 4, 2, 1
            PH_NORM:
            begin
                if ((m_reg >> (6'd32 - sh)) == 32'd0)
                begin
                    m_next = m_reg << sh;
                    p_next = p_reg - 5'(sh);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd4)
                    phase_next = PH_SEED;
            end
            PH_SEED:
            begin
                m_next     = m_reg >> 1;
                l2_next    = l2_seed;
                cnt_next   = 5'd29;
                phase_next = PH_ITER;
            end
            // one fraction bit of log2 per squaring
            PH_ITER:
            begin
                if (mm[31])
                begin
                    m_next  = {1'b0, mm[31:1]};
                    l2_next = l2_reg + (37'sd1 <<< cnt_reg);
                end
                else
                begin
                    m_next = mm;
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 5'd0)
                    phase_next = PH_SCALE;
            end
            PH_SCALE:
            begin
                ln_next    = LN_W'(lnp >>> 32);
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
        l2_reg  <= l2_next;
        ln_reg  <= ln_next;
    end

    assign busy   = (phase_reg != PH_IDLE);
    assign ln_out = ln_reg;

endmodule

FILE: design/dgos_dp.sv
// Datapath: element stores, shared multiplier, score accumulator, output register.
module dgos_dp
    import dgos_pkg::*;
#(
    parameter int DIM       = DIM_DEFAULT,
    parameter int FRAC_BITS = FRAC_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              status,
    input  logic [1:0]              opcode,
    input  logic [3:0]              element_index,
    input  logic signed [31:0]      sample_value,
    input  logic [31:0]             load_variance,
    input  logic                    last_element,
    input  logic                    cfg_we,
    input  logic [ALPHA_W-1:0]      cfg_wdata,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ACC_W-1:0] log_likelihood,
    output logic                    variance_error
);

    localparam int AW  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int MCW = $clog2(MUL_STEPS);

    // request fields held for the whole item
    opcode_t            op_reg;
    logic [3:0]         idx_reg;
    logic signed [31:0] x_reg;
    logic [31:0]        lv_reg;
    logic               last_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    logic signed [31:0] mean_store_reg [DIM];
    logic [31:0]        var_store_reg  [DIM];
    logic signed [31:0] mean_q_reg;
    logic [31:0]        var_q_reg;

    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    t_reg;
    logic signed [31:0] nm_reg;

    logic [MUL_P_W-1:0] mx_reg;
    logic [MUL_Y_W-1:0] my_reg;
    logic [MUL_P_W-1:0] prod_reg;
    logic [MCW-1:0]     mcnt_reg;
    logic               mbusy_reg;
    logic               mneg_reg;

    logic signed [ACC_W-1:0] acc_reg;
    logic                    err_reg;
    logic signed [ACC_W-1:0] ll_reg;
    logic                    verr_reg;
    logic                    out_valid_reg;

    logic [AW-1:0]        addr;
    logic signed [32:0]   d;
    logic [32:0]          ad;
    logic signed [48:0]   diff;
    logic [48:0]          adiff;
    logic [MUL_X_W-1:0]   mx_in;
    logic [MUL_Y_W-1:0]   my_in;
    logic                 mneg_in;
    logic signed [MUL_P_W:0] ps;
    logic signed [MUL_P_W:0] ps16;
    logic [MUL_P_W-1:0]   sq_full;
    logic signed [83:0]   nm_wide;
    logic signed [83:0]   nv_wide;
    logic signed [31:0]   nm_next;
    logic [31:0]          nv_next;

    logic                    div_busy;
    logic                    ln_busy;
    logic [Q_W-1:0]          quot;
    logic signed [LN_W-1:0]  ln_val;
    logic signed [52:0]      total;
    logic signed [52:0]      half;
    logic signed [53:0]      acc_wide;
    logic signed [ACC_W-1:0] acc_next;

    assign addr = AW'(idx_reg);

    // difference to the stored mean and its magnitude
    always_comb
    begin
        d     = $signed({x_reg[31], x_reg}) - $signed({mean_q_reg[31], mean_q_reg});
        ad    = d[32] ? 33'(-d) : 33'(d);
        diff  = $signed({2'b00, t_reg}) - $signed({17'd0, var_q_reg});
        adiff = diff[48] ? 49'(-diff) : 49'(diff);
    end

    // multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MS_SQUARE:
            begin
                mx_in   = {16'd0, ad};
                my_in   = ad;
                mneg_in = 1'b0;
            end
            MS_DECAY:
            begin
                mx_in   = {2'b00, sq_reg};
                my_in   = {16'd0, 17'(ALPHA_ONE - {1'b0, alpha_reg})};
                mneg_in = 1'b0;
            end
            MS_MEAN:
            begin
                mx_in   = {16'd0, ad};
                my_in   = {17'd0, alpha_reg};
                mneg_in = d[32];
            end
            MS_VAR:
            begin
                mx_in   = adiff;
                my_in   = {17'd0, alpha_reg};
                mneg_in = diff[48];
            end
            default:
            begin
                mx_in   = '0;
                my_in   = '0;
                mneg_in = 1'b0;
            end
        endcase
    end

    // product post-processing for the update path
    always_comb
    begin
        ps      = mneg_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
        ps16    = ps >>> 16;
        sq_full = prod_reg >> FRAC_BITS;

        nm_wide = $signed({{52{mean_q_reg[31]}}, mean_q_reg}) + $signed({ps16[MUL_P_W], ps16});
        if (nm_wide > $signed(84'h7FFF_FFFF))
            nm_next = 32'sh7FFF_FFFF;
        else if (nm_wide < -$signed(84'h8000_0000))
            nm_next = -32'sh8000_0000;
        else
            nm_next = nm_wide[31:0];

        nv_wide = $signed({52'd0, var_q_reg}) + $signed({ps16[MUL_P_W], ps16});
        if (nv_wide < 0)
            nv_next = '0;
        else if (nv_wide > $signed(84'hFFFF_FFFF))
            nv_next = '1;
        else
            nv_next = nv_wide[31:0];
    end

    // score term and saturating accumulate
    always_comb
    begin
        total    = $signed({{(53-LN_W){ln_val[LN_W-1]}}, ln_val}) + $signed({2'b00, quot});
        half     = total >>> 1;
        acc_wide = $signed({{6{acc_reg[ACC_W-1]}}, acc_reg}) - $signed({half[52], half});
        if (acc_wide[53:ACC_W-1] != {7{acc_wide[53]}})
            acc_next = acc_wide[53] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_next = acc_wide[ACC_W-1:0];
    end

    dgos_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.score_start),
        .dividend (prod_reg[64:0]),
        .divisor  (var_q_reg),
        .busy     (div_busy),
        .quot     (quot)
    );

    dgos_ln #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ln (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.score_start),
        .v      (var_q_reg),
        .busy   (ln_busy),
        .ln_out (ln_val)
    );

    // control state: config, multiplier sequencing, accumulator, error flag, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg     <= ALPHA_RESET;
            mbusy_reg     <= 1'b0;
            mcnt_reg      <= '0;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                alpha_reg <= cfg_wdata;

            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1;
                mcnt_reg  <= '0;
            end
            else if (mbusy_reg)
            begin
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mcnt_reg == MCW'(MUL_STEPS - 1))
                    mbusy_reg <= 1'b0;
            end

            if (cmd.acc_update)
                acc_reg <= acc_next;
            if (cmd.err_set)
                err_reg <= 1'b1;

            if (cmd.emit)
            begin
                acc_reg       <= '0;
                err_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, element stores, multiplier digit steps and result captures
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode_t'(opcode);
            idx_reg  <= element_index;
            x_reg    <= sample_value;
            lv_reg   <= load_variance;
            last_reg <= last_element;
        end

        if (cmd.mem_read)
        begin
            mean_q_reg <= mean_store_reg[addr];
            var_q_reg  <= var_store_reg[addr];
        end

        if (cmd.load_write)
        begin
            mean_store_reg[addr] <= x_reg;
            var_store_reg[addr]  <= lv_reg;
        end
        else if (cmd.nv_write)
        begin
            mean_store_reg[addr] <= nm_reg;
            var_store_reg[addr]  <= nv_next;
        end

        if (cmd.mul_start)
        begin
            mx_reg   <= {{(MUL_P_W-MUL_X_W){1'b0}}, mx_in};
            my_reg   <= my_in;
            prod_reg <= '0;
            mneg_reg <= mneg_in;
        end
        else if (mbusy_reg)
        begin
            prod_reg <= prod_reg + MUL_P_W'(mx_reg * {{(MUL_P_W-MUL_DIGIT){1'b0}},
                                                      my_reg[MUL_DIGIT-1:0]});
            mx_reg   <= mx_reg << MUL_DIGIT;
            my_reg   <= my_reg >> MUL_DIGIT;
        end

        if (cmd.sq_capture)
            sq_reg <= (sq_full > MUL_P_W'(SQ_CAP)) ? SQ_CAP : sq_full[SQ_W-1:0];
        if (cmd.t_capture)
            t_reg <= prod_reg[16 +: SQ_W];
        if (cmd.nm_capture)
            nm_reg <= nm_next;

        if (cmd.emit)
        begin
            ll_reg   <= acc_reg;
            verr_reg <= err_reg;
        end
    end

    always_comb
    begin
        status.op         = op_reg;
        status.last       = last_reg;
        status.idx_ok     = (int'(idx_reg) < DIM);
        status.var_zero   = (var_q_reg == 32'd0);
        status.mul_busy   = mbusy_reg;
        status.score_busy = div_busy | ln_busy;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign log_likelihood = ll_reg;
    assign variance_error = verr_reg;

endmodule

FILE: design/dgos_ctrl.sv
// Controller: sequences load, update and score operations over the datapath.
module dgos_ctrl
    import dgos_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DECODE,
        S_SQ,
        S_SQ_W,
        S_DECAY,
        S_DECAY_W,
        S_MEAN,
        S_MEAN_W,
        S_VAR,
        S_VAR_W,
        S_SC_SQ,
        S_SC_SQ_W,
        S_SC_W,
        S_LAST
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MS_SQUARE;
        in_ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_DECODE;
            end
            S_DECODE:
            begin
                case (status.op)
                    OP_LOAD:
                    begin
                        cmd.load_write = status.idx_ok;
                        state_next     = S_IDLE;
                    end
                    OP_UPDATE:
                    begin
                        state_next = status.idx_ok ? S_SQ : S_IDLE;
                    end
                    OP_SCORE:
                    begin
                        if (!status.idx_ok)
                            state_next = S_LAST;
                        else if (status.var_zero)
                        begin
                            cmd.err_set = 1'b1;
                            state_next  = S_LAST;
                        end
                        else
                            state_next = S_SC_SQ;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            // update: d*d, decay term, new mean, new variance
            S_SQ:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SQUARE;
                state_next    = S_SQ_W;
            end
            S_SQ_W:
            begin
                if (!status.mul_busy)
                begin
                    cmd.sq_capture = 1'b1;
                    state_next     = S_DECAY;
                end
            end
            S_DECAY:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_DECAY;
                state_next    = S_DECAY_W;
            end
            S_DECAY_W:
            begin
                if (!status.mul_busy)
                begin
                    cmd.t_capture = 1'b1;
                    state_next    = S_MEAN;
                end
            end
            S_MEAN:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_MEAN;
                state_next    = S_MEAN_W;
            end
            S_MEAN_W:
            begin
                if (!status.mul_busy)
                begin
                    cmd.nm_capture = 1'b1;
                    state_next     = S_VAR;
                end
            end
            S_VAR:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_VAR;
                state_next    = S_VAR_W;
            end
            S_VAR_W:
            begin
                cmd.mul_sel = MS_VAR;
                if (!status.mul_busy)
                begin
                    cmd.nv_write = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            // score: d*d, then divide and log in parallel
            S_SC_SQ:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MS_SQUARE;
                state_next    = S_SC_SQ_W;
            end
            S_SC_SQ_W:
            begin
                if (!status.mul_busy)
                begin
                    cmd.score_start = 1'b1;
                    state_next      = S_SC_W;
                end
            end
            S_SC_W:
            begin
                if (!status.score_busy)
                begin
                    cmd.acc_update = 1'b1;
                    state_next     = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!status.last)
                    state_next = S_IDLE;
                else if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: design/diagonal_gaussian_online_scorer.sv
// Top level: diagonal Gaussian log-likelihood scorer with online update.
//
//   channel     dir  handshake          payload
//   sample_in   in   valid/ready        opcode, element_index, sample_value,
//                                       load_variance, last_element
//   score_out   out  valid/ready        log_likelihood, variance_error
//   cfg         in   cfg_we             cfg_wdata (rate_alpha)
//
// One request at a time. Load, unused opcode: capture, read, decode. Update: four
// passes on the shared multiplier (start, five digit steps, done). Score: a
// multiplier pass, then a wait on the log unit (the divider runs alongside), then
// emit; zero variance or bad index: straight to emit. Reset clears the accumulator,
// the error flag and the output valid flag; the element stores hold nothing
// defined until loaded. A stalled result waits in the output register while the
// next request is taken.
module diagonal_gaussian_online_scorer
    import dgos_pkg::*;
#(
    parameter int DIM       = DIM_DEFAULT,
    parameter int FRAC_BITS = FRAC_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    dgos_in_if.sink            sample_in,
    dgos_out_if.source         score_out,
    input  logic               cfg_we,
    input  logic [ALPHA_W-1:0] cfg_wdata
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    dgos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dgos_dp #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (sample_in.opcode),
        .element_index  (sample_in.element_index),
        .sample_value   (sample_in.sample_value),
        .load_variance  (sample_in.load_variance),
        .last_element   (sample_in.last_element),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .out_valid      (score_out.valid),
        .out_ready      (score_out.ready),
        .log_likelihood (score_out.log_likelihood),
        .variance_error (score_out.variance_error)
    );

endmodule

FILE: bench/tb.sv
// Self-checking bench for the diagonal Gaussian online scorer: random traffic against a predictor.
module tb;
    import dgos_pkg::*;

    typedef struct {
        opcode_t          op;
        logic [3:0]       idx;
        logic [31:0]      x;
        logic [31:0]      lv;
        logic             last;
    } sample_req_t;

    typedef struct {
        logic signed [47:0] ll;
        logic               err;
        int                 terms;
    } score_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ALPHA_W-1:0] cfg_wdata;

    dgos_in_if  sin();
    dgos_out_if sout();

    diagonal_gaussian_online_scorer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sin),
        .score_out (sout),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state
    longint        pm_mean [16];
    longint        pm_var  [16];
    longint        pm_acc;
    logic          pm_err;
    int            pm_terms;
    longint        pm_alpha;

    sample_req_t   pending_q[$];
    score_t        score_q[$];
    logic          calm;
    int            send_idle;
    int            recv_idle;
    int            n_accepted;
    int            n_scores;
    int            n_fail;
    int            n_zero_var;

    // ln(v / 2^16) in Q16 by repeated squaring
    function automatic longint ln_q16(logic [31:0] v);
        int p;
        longint unsigned m;
        longint l2;
        p = 31;
        while (p > 0 && !v[p])
            p--;
        if (p <= 30)
            m = longint'(v) << (30 - p);
        else
            m = longint'(v) >> (p - 30);
        l2 = longint'(p - 16) * (64'sd1 << 30);
        for (int i = 29; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                l2 = l2 + (64'sd1 <<< i);
            end
        end
        l2 = l2 >>> 10;
        return (l2 * 64'sd186065280) >>> 32;
    endfunction

    // Apply one accepted request to the predictor
    task automatic predict(sample_req_t r);
        longint d, nm, nv, t, xs;
        longint unsigned ad, sq, q;
        score_t s;
        xs = longint'($signed(r.x));
        if (r.op == OP_LOAD)
        begin
            pm_mean[r.idx] = xs;
            pm_var[r.idx]  = longint'(r.lv);
        end
        else if (r.op == OP_UPDATE)
        begin
            d  = xs - pm_mean[r.idx];
            ad = (d < 0) ? -d : d;
            sq = (ad * ad) >> 16;
            if (sq > 64'h7FFF_FFFF_FFFF)
                sq = 64'h7FFF_FFFF_FFFF;
            nm = pm_mean[r.idx] + ((pm_alpha * d) >>> 16);
            if (nm > 64'sd2147483647)
                nm = 64'sd2147483647;
            if (nm < -64'sd2147483648)
                nm = -64'sd2147483648;
            t  = longint'(((65536 - pm_alpha) * sq) >> 16);
            nv = pm_var[r.idx] + ((pm_alpha * (t - pm_var[r.idx])) >>> 16);
            if (nv < 0)
                nv = 0;
            if (nv > 64'sh0_FFFF_FFFF)
                nv = 64'sh0_FFFF_FFFF;
            pm_mean[r.idx] = nm;
            pm_var[r.idx]  = nv;
        end
        else if (r.op == OP_SCORE)
        begin
            if (pm_var[r.idx] == 0)
            begin
                pm_err = 1'b1;
                n_zero_var++;
            end
            else
            begin
                d  = xs - pm_mean[r.idx];
                ad = (d < 0) ? -d : d;
                q  = (ad * ad) / longint'(pm_var[r.idx]);
                if (q > (64'd1 << 50))
                    q = 64'd1 << 50;
                t = ln_q16(pm_var[r.idx][31:0]) + longint'(q);
                pm_acc = pm_acc - (t >>> 1);
                if (pm_acc > (64'sd1 <<< 47) - 1)
                    pm_acc = (64'sd1 <<< 47) - 1;
                if (pm_acc < -(64'sd1 <<< 47))
                    pm_acc = -(64'sd1 <<< 47);
                pm_terms++;
            end
            if (r.last)
            begin
                s.ll    = pm_acc[47:0];
                s.err   = pm_err;
                s.terms = pm_terms;
                score_q.push_back(s);
                pm_acc   = 0;
                pm_err   = 1'b0;
                pm_terms = 0;
            end
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sin.valid         <= 1'b0;
            sin.opcode        <= OP_LOAD;
            sin.element_index <= '0;
            sin.sample_value  <= '0;
            sin.load_variance <= '0;
            sin.last_element  <= 1'b0;
            send_idle         = 0;
        end
        else if (!(sin.valid && !sin.ready))
        begin
            if (sin.valid && sin.ready)
            begin
                predict(pending_q[0]);
                pending_q.pop_front();
                n_accepted++;
            end
            if (send_idle > 0)
                send_idle--;
            else if (!calm && $urandom_range(0, 7) == 0)
                send_idle = $urandom_range(1, 5);
            if (send_idle == 0 && pending_q.size() > 0)
            begin
                sin.valid         <= 1'b1;
                sin.opcode        <= pending_q[0].op;
                sin.element_index <= pending_q[0].idx;
                sin.sample_value  <= pending_q[0].x;
                sin.load_variance <= pending_q[0].lv;
                sin.last_element  <= pending_q[0].last;
            end
            else
                sin.valid <= 1'b0;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sout.ready <= 1'b0;
            recv_idle  = 0;
        end
        else
        begin
            if (sout.valid && sout.ready)
            begin
                if (score_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected score %0d err %0b", sout.log_likelihood,
                                 sout.variance_error);
                end
                else
                begin
                    longint diff;
                    diff = longint'(sout.log_likelihood) - longint'(score_q[0].ll);
                    if (diff < 0)
                        diff = -diff;
                    if (diff > 3 * score_q[0].terms || sout.variance_error !== score_q[0].err)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display("score mismatch: expected %0d err %0b, got %0d err %0b",
                                     score_q[0].ll, score_q[0].err, sout.log_likelihood,
                                     sout.variance_error);
                    end
                    score_q.pop_front();
                    n_scores++;
                end
            end
            if (recv_idle > 0)
                recv_idle--;
            else if (!calm && $urandom_range(0, 7) == 0)
                recv_idle = $urandom_range(1, 5);
            sout.ready <= (recv_idle == 0);
        end
    end

    task automatic add(opcode_t op, int idx, logic [31:0] x, logic [31:0] lv, logic last);
        sample_req_t r;
        r.op = op; r.idx = idx[3:0]; r.x = x; r.lv = lv; r.last = last;
        pending_q.push_back(r);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] rand_var();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom;
            default: return $urandom_range(1, 1 << 20);
        endcase
    endfunction

    // Random traffic, mostly well-formed scoring vectors
    task automatic random_traffic(int n);
        int k, base, cnt;
        cnt = 0;
        while (cnt < n)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    add(OP_LOAD, $urandom_range(0, 15), rand_sample(), rand_var(),
                        1'($urandom_range(0, 1)));
                    cnt++;
                end
                3:
                begin
                    add(OP_NONE, $urandom_range(0, 15), $urandom, $urandom,
                        1'($urandom_range(0, 1)));
                end
                4:
                begin
                    // broken vector: no last mark, sum carries on
                    add(OP_SCORE, $urandom_range(0, 15), rand_sample(), $urandom, 1'b0);
                    cnt++;
                end
                default:
                begin
                    k = $urandom_range(1, 6);
                    base = $urandom_range(0, 15);
                    for (int i = 0; i < k; i++)
                        if ($urandom_range(0, 2) == 0)
                        begin
                            add(OP_UPDATE, (base + i) % 16, rand_sample(), $urandom,
                                1'($urandom_range(0, 1)));
                            cnt++;
                        end
                    for (int i = 0; i < k; i++)
                    begin
                        add(OP_SCORE, (base + i) % 16, rand_sample(), $urandom, i == k - 1);
                        cnt++;
                    end
                end
            endcase
        end
    endtask

    // Wait for the block to drain, then set the rate
    task automatic set_alpha(logic [15:0] a);
        while (pending_q.size() > 0 || score_q.size() > 0 || sin.valid)
            @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        pm_alpha  = longint'(a);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stimulus phases
    initial
    begin
        calm = 1'b0; n_accepted = 0; n_scores = 0; n_fail = 0; n_zero_var = 0;
        pm_acc = 0; pm_err = 1'b0; pm_terms = 0; pm_alpha = 655;
        for (int i = 0; i < 16; i++)
        begin
            pm_mean[i] = 0;
            pm_var[i]  = 0;
        end
        cfg_we = 1'b0;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, every opcode, zero variance, stray last marks
        add(OP_LOAD, 0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        add(OP_LOAD, 15, 32'h7FFF_FFFF, 32'd1, 1'b1);
        for (int i = 1; i < 15; i++)
            add(OP_LOAD, i, rand_sample(), $urandom_range(1, 1 << 20), 1'b0);
        add(OP_SCORE, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add(OP_SCORE, 15, 32'h8000_0000, 32'd0, 1'b1);
        add(OP_LOAD, 3, 32'd0, 32'd0, 1'b0);
        add(OP_SCORE, 3, 32'd65536, 32'd0, 1'b1);
        add(OP_UPDATE, 5, 32'h7FFF_FFFF, 32'd0, 1'b1);
        add(OP_SCORE, 5, 32'h0001_0000, 32'd0, 1'b1);
        add(OP_NONE, 6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add(OP_SCORE, 7, 32'd0, 32'd0, 1'b1);
        random_traffic(110);

        set_alpha(16'hFFFF);
        random_traffic(125);
        set_alpha(16'h0000);
        random_traffic(125);
        set_alpha(16'($urandom));
        random_traffic(60);
        set_alpha(16'd655);
        calm = 1'b1;
        random_traffic(60);

        while (pending_q.size() > 0 || score_q.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d requests and %0d scores, %0d zero-variance elements,",
                 n_accepted, n_scores, n_zero_var);
        $display("over rates 655, max, zero and a random one.");
        if (n_fail == 0 && score_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
